// ===== rtl/fcas_pkg.sv =====
// ----------------------------------------------------------------------------
// fcas_pkg
// Shared types and constants for the delimited frame checker with 8-bit
// additive checksum.
// ----------------------------------------------------------------------------
package fcas_pkg;

  // frame delimiters
  localparam logic [7:0] MarkStart   = 8'h40;  // '@'
  localparam logic [7:0] MarkEquals  = 8'h3D;  // '='
  localparam logic [7:0] MarkEnd     = 8'h23;  // '#'

  // header plus trailer bytes around the payload
  localparam int unsigned FrameOverhead = 6;
  localparam int unsigned HeaderBytes   = 4;

  localparam int unsigned PosW   = 9;
  localparam logic [PosW-1:0] PosMax = '1;

  // configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic RegFormatLimit  = 1'b0;   // register index, paddr[2]
  localparam logic [7:0] FormatLimitReset = 8'hFF;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StMarker    = 2'd1,
    StLength    = 2'd2,
    StFormatSum = 2'd3
  } status_t;

  typedef enum logic {
    KindData   = 1'b0,
    KindStatus = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    status_t    status;
    logic [7:0] format_id;
    logic [7:0] payload_length;
  } res_t;

endpackage

// ===== rtl/fcas_ifs.sv =====
// ----------------------------------------------------------------------------
// fcas_ifs
// Valid/ready stream interfaces for received bytes and checker results.
// ----------------------------------------------------------------------------
interface fcas_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, output rx_byte, output last_byte, input ready);
  modport sink   (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface fcas_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic [7:0] format_id;
  logic [7:0] payload_length;

  modport source (output valid, output kind, output data_byte, output status,
                  output format_id, output payload_length, input ready);
  modport sink   (input valid, input kind, input data_byte, input status,
                  input format_id, input payload_length, output ready);
endinterface

// ===== rtl/fcas_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fcas_cfg_regs
// APB-style register file holding the format id limit.
// ----------------------------------------------------------------------------
module fcas_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcas_pkg::CfgAddrW-1:0] paddr,
  input  logic [fcas_pkg::CfgDataW-1:0] pwdata,
  output logic [fcas_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    format_limit
);

  logic [7:0] format_limit_r;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == fcas_pkg::RegFormatLimit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_limit_r <= fcas_pkg::FormatLimitReset;
    end else if (wr_en) begin
      format_limit_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == fcas_pkg::RegFormatLimit) begin
      prdata = {{(fcas_pkg::CfgDataW-8){1'b0}}, format_limit_r};
    end
  end

  assign format_limit = format_limit_r;

endmodule

// ===== rtl/fcas_frame_check.sv =====
// ----------------------------------------------------------------------------
// fcas_frame_check
// Per-frame state and the single-pass check of one received byte.
// ----------------------------------------------------------------------------
module fcas_frame_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,        // byte transaction this cycle
  input  logic [7:0]         rx_byte,
  input  logic               last_byte,
  input  logic [7:0]         format_limit,
  output logic               emit,        // byte yields a result
  output fcas_pkg::res_t     res
);

  localparam int unsigned PosW = fcas_pkg::PosW;

  logic [PosW-1:0] pos_r;
  logic            start_ok_r;
  logic            equals_ok_r;
  logic [7:0]      format_r;
  logic [7:0]      length_r;
  logic [7:0]      sum_r;
  logic [7:0]      prev0_r;
  logic [7:0]      prev1_r;

  logic            start_ok_nxt;
  logic            equals_ok_nxt;
  logic [7:0]      format_nxt;
  logic [7:0]      length_nxt;
  logic [7:0]      sum_nxt;
  logic [PosW-1:0] pos_inc;
  logic            markers_ok;
  logic            length_ok;
  logic            fwd;
  logic [PosW:0]   fwd_end;
  fcas_pkg::status_t st;

  always_comb begin
    start_ok_nxt  = start_ok_r;
    equals_ok_nxt = equals_ok_r;
    format_nxt    = format_r;
    length_nxt    = length_r;
    case (pos_r)
      PosW'(0): start_ok_nxt  = (rx_byte == fcas_pkg::MarkStart);
      PosW'(1): format_nxt    = rx_byte;
      PosW'(2): length_nxt    = rx_byte;
      PosW'(3): equals_ok_nxt = (rx_byte == fcas_pkg::MarkEquals);
      default: ;
    endcase
  end

  // byte two places back enters the sum once it lies past the header
  assign sum_nxt = (pos_r >= PosW'(fcas_pkg::FrameOverhead)) ? sum_r + prev1_r : sum_r;
  assign pos_inc = (pos_r == fcas_pkg::PosMax) ? pos_r : pos_r + PosW'(1);

  // size = pos+1; size-6 == length  <=>  pos >= 5 and pos-5 == length
  assign markers_ok = start_ok_nxt & equals_ok_nxt
                    & (pos_r >= PosW'(fcas_pkg::HeaderBytes - 1))
                    & (rx_byte == fcas_pkg::MarkEnd);
  assign length_ok  = (pos_r >= PosW'(fcas_pkg::FrameOverhead - 1))
                    & ((pos_r - PosW'(fcas_pkg::FrameOverhead - 1))
                       == {{(PosW-8){1'b0}}, length_nxt});

  always_comb begin
    if (!markers_ok) begin
      st = fcas_pkg::StMarker;
    end else if (!length_ok) begin
      st = fcas_pkg::StLength;
    end else if ((format_nxt > format_limit) || (sum_nxt != prev0_r)) begin
      st = fcas_pkg::StFormatSum;
    end else begin
      st = fcas_pkg::StOk;
    end
  end

  assign fwd_end = (PosW+1)'(fcas_pkg::HeaderBytes) + {{(PosW-7){1'b0}}, length_nxt};
  assign fwd     = (pos_r >= PosW'(fcas_pkg::HeaderBytes)) & ({1'b0, pos_r} < fwd_end);
  assign emit    = last_byte | fwd;

  always_comb begin
    res = '0;
    if (last_byte) begin
      res.kind           = fcas_pkg::KindStatus;
      res.status         = st;
      res.format_id      = format_nxt;
      res.payload_length = length_nxt;
    end else begin
      res.kind      = fcas_pkg::KindData;
      res.data_byte = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_ok_r  <= 1'b0;
      equals_ok_r <= 1'b0;
      format_r    <= '0;
      length_r    <= '0;
      sum_r       <= '0;
      prev0_r     <= '0;
      prev1_r     <= '0;
    end else if (take) begin
      if (last_byte) begin
        pos_r       <= '0;
        start_ok_r  <= 1'b0;
        equals_ok_r <= 1'b0;
        format_r    <= '0;
        length_r    <= '0;
        sum_r       <= '0;
        prev0_r     <= '0;
        prev1_r     <= '0;
      end else begin
        pos_r       <= pos_inc;
        start_ok_r  <= start_ok_nxt;
        equals_ok_r <= equals_ok_nxt;
        format_r    <= format_nxt;
        length_r    <= length_nxt;
        sum_r       <= sum_nxt;
        prev0_r     <= rx_byte;
        prev1_r     <= prev0_r;
      end
    end
  end

endmodule

// ===== rtl/fcas_out_reg.sv =====
// ----------------------------------------------------------------------------
// fcas_out_reg
// Result register; frees itself in the cycle its transaction completes.
// ----------------------------------------------------------------------------
module fcas_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  fcas_pkg::res_t res,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output fcas_pkg::res_t out_res
);

  logic           valid_r;
  fcas_pkg::res_t res_r;

  assign can_load = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== rtl/frame_checker_additive_sum_core.sv =====
// ----------------------------------------------------------------------------
// frame_checker_additive_sum_core
// Delimited frame checker with 8-bit additive checksum, top level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one frame byte per transaction, last_byte set on the final byte.
//            Frame layout is '@', format id, length, '=', payload, sum, '#'.
//   out_ch : payload bytes are forwarded (kind 0) as they arrive; the last
//            byte of a frame gives one status transaction (kind 1) carrying
//            status, format id and length byte. Other bytes give nothing.
//   APB    : register 0 at address 0 is the highest accepted format id
//            (reset 255). Write only while the block is idle.
// Latency: a result is presented the cycle after its byte is taken.
// Throughput: one byte per cycle unless out_ch stalls, set by the single output
//   register; the per-byte work is a handful of compares and one 8-bit add.
// Stall: in_ch.ready drops only while a result is held and out_ch.ready is
//   low; a pending result never blocks a byte that the receiver drains.
// Reset: synchronous, active low; clears frame state and the result
//   valid flag, format limit returns to 255.
// ----------------------------------------------------------------------------
module frame_checker_additive_sum_core (
  input  logic                          clk,
  input  logic                          rst_n,
  fcas_in_if.sink                       in_ch,
  fcas_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcas_pkg::CfgAddrW-1:0] paddr,
  input  logic [fcas_pkg::CfgDataW-1:0] pwdata,
  output logic [fcas_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  logic           in_take;     // byte transaction completes
  logic           can_load;    // result register free this cycle
  logic           emit;        // current byte gives a result
  logic [7:0]     format_limit;
  fcas_pkg::res_t res;
  fcas_pkg::res_t out_res;

  fcas_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .format_limit (format_limit)
  );

  // byte taken whenever the result register can absorb whatever it yields
  assign in_ch.ready = can_load;
  assign in_take     = in_ch.valid & can_load;

  fcas_frame_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_take),
    .rx_byte      (in_ch.rx_byte),
    .last_byte    (in_ch.last_byte),
    .format_limit (format_limit),
    .emit         (emit),
    .res          (res)
  );

  fcas_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take & emit),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.kind           = out_res.kind;
  assign out_ch.data_byte      = out_res.data_byte;
  assign out_ch.status         = out_res.status;
  assign out_ch.format_id      = out_res.format_id;
  assign out_ch.payload_length = out_res.payload_length;

endmodule
